// ===== hw/rtl/lidar_polar_to_cartesian_macros.svh =====
// assertion helpers for the polar to cartesian block
// both expect i_clk and i_rst_n in the scope of the use
`ifndef LIDAR_POLAR_TO_CARTESIAN_MACROS_SVH
`define LIDAR_POLAR_TO_CARTESIAN_MACROS_SVH

// property checked on every rising clock edge outside reset
`define LPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define LPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lpc_pkg.sv =====
`default_nettype none

package lpc_pkg;

    localparam int SCAN_MAX     = 4096;
    localparam int CORDIC_STEPS = 16;

    localparam int RANGE_W    = 16;
    localparam int ANGLE_W    = 16;
    localparam int XY_W       = 17;
    localparam int COUNT_W    = 13;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // datapath widths: x/y grow to about r * 2^16, z stays within a quarter turn
    localparam int ACC_W  = 35;
    localparam int Z_W    = 34;
    localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    localparam logic [31:0] GAIN_Q32 = 32'h9B74EDA8;
    localparam int          XY_LIMIT = 65535;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GATE_LO,
        CFG_GATE_HI,
        CFG_ANGLE_START,
        CFG_ANGLE_STEP
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        C_IDLE,
        C_MUL,
        C_ROT,
        C_RND
    } t_cordic_state;

    typedef struct packed {
        logic               start;
        logic [RANGE_W-1:0] range;
        logic [ANGLE_W-1:0] angle;
    } t_cordic_req;

    typedef struct packed {
        logic                   done;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
    } t_cordic_rsp;

    // arctangent of 2^-i, 2^32 units per turn
    function automatic logic [31:0] atan_turn32(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lpc_ifs.sv =====
`default_nettype none

// sample channel
interface lpc_in_if;
    import lpc_pkg::*;

    logic               valid;
    logic               ready;
    logic [RANGE_W-1:0] range_mm;
    logic               scan_end;

    modport source (output valid, output range_mm, output scan_end, input ready);
    modport sink   (input valid, input range_mm, input scan_end, output ready);
endinterface

// point channel
interface lpc_out_if;
    import lpc_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [XY_W-1:0] x_mm;
    logic signed [XY_W-1:0] y_mm;
    logic                   point_kept;
    logic                   scan_done;
    logic [COUNT_W-1:0]     kept_count;

    modport source (output valid, output x_mm, output y_mm, output point_kept,
                    output scan_done, output kept_count, input ready);
    modport sink   (input valid, input x_mm, input y_mm, input point_kept,
                    input scan_done, input kept_count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lidar_polar_to_cartesian.sv =====
// Converts scanning range samples (mm) into cartesian points by CORDIC rotation.
// Each sample on i_pt gives exactly one result on o_pt: x/y in mm (zero when the
// sample is dropped), a kept flag, the scan_end echo and the running kept count
// of the scan, saturating at SCAN_MAX. The beam angle (65536 units per turn)
// loads from angle_start on the first sample of a scan and advances by
// angle_step on every later one. A sample is kept when its range lies strictly
// between the low and high gate registers. One item is in flight at a time: a
// kept sample passes through the single shared CORDIC stage, which does a
// multiply, one rotation per cycle for CORDIC_STEPS steps and a rounding,
// then goes to the handoff into the output register; a dropped sample goes
// straight to the handoff. Either one waits there while the output register
// still holds an unaccepted result.
// Configuration writes go straight into the registers and should land while
// the block is idle; angle_start takes effect at the next scan start.
`default_nettype none

module lidar_polar_to_cartesian (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    lpc_in_if.sink                         i_pt,
    lpc_out_if.source                      o_pt,
    input  wire                            i_cfg_we,
    input  wire [lpc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [lpc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import lpc_pkg::*;

    // configuration registers
    logic [RANGE_W-1:0]     r_gate_lo, n_gate_lo;
    logic [RANGE_W-1:0]     r_gate_hi, n_gate_hi;
    logic [ANGLE_W-1:0]     r_angle_start, n_angle_start;
    logic [ANGLE_W-1:0]     r_angle_step, n_angle_step;

    // scan state
    logic [ANGLE_W-1:0]     r_beam_angle, n_beam_angle;
    logic                   r_first, n_first;
    logic [COUNT_W-1:0]     r_kept_total, n_kept_total;

    // sequencer
    t_state                 r_state, n_state;

    // item being worked on
    logic                   r_last, n_last;
    logic                   r_kept, n_kept;
    logic [COUNT_W-1:0]     r_count, n_count;
    logic signed [XY_W-1:0] r_px, n_px;
    logic signed [XY_W-1:0] r_py, n_py;

    // output register
    logic                   r_out_valid, n_out_valid;
    logic signed [XY_W-1:0] r_out_x, n_out_x;
    logic signed [XY_W-1:0] r_out_y, n_out_y;
    logic                   r_out_kept, n_out_kept;
    logic                   r_out_done, n_out_done;
    logic [COUNT_W-1:0]     r_out_count, n_out_count;

    logic                   w_in_acc;
    logic                   w_out_acc;
    logic [ANGLE_W-1:0]     w_angle;
    logic                   w_kept;
    logic [COUNT_W-1:0]     w_count;
    t_cordic_req            w_req;
    t_cordic_rsp            w_rsp;

    assign i_pt.ready = (r_state == S_IDLE);
    assign w_in_acc   = i_pt.valid & i_pt.ready;
    assign w_out_acc  = r_out_valid & o_pt.ready;

    // beam angle of this sample, wraps modulo a turn
    assign w_angle = r_first ? r_angle_start : r_beam_angle + r_angle_step;

    // range gate, strict on both sides (empty gate keeps nothing)
    assign w_kept = (i_pt.range_mm > r_gate_lo) && (i_pt.range_mm < r_gate_hi);

    // count including this sample, held at the scan limit
    assign w_count = (w_kept && (r_kept_total < COUNT_W'(SCAN_MAX)))
                   ? r_kept_total + 1'b1 : r_kept_total;

    assign w_req.start = w_in_acc & w_kept;
    assign w_req.range = i_pt.range_mm;
    assign w_req.angle = w_angle;

    lpc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // configuration writes
    always_comb begin
        n_gate_lo     = r_gate_lo;
        n_gate_hi     = r_gate_hi;
        n_angle_start = r_angle_start;
        n_angle_step  = r_angle_step;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_GATE_LO:     n_gate_lo     = RANGE_W'(i_cfg_data);
                CFG_GATE_HI:     n_gate_hi     = RANGE_W'(i_cfg_data);
                CFG_ANGLE_START: n_angle_start = ANGLE_W'(i_cfg_data);
                CFG_ANGLE_STEP:  n_angle_step  = ANGLE_W'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // sequencer and item bookkeeping
    always_comb begin
        n_state      = r_state;
        n_beam_angle = r_beam_angle;
        n_first      = r_first;
        n_kept_total = r_kept_total;
        n_last       = r_last;
        n_kept       = r_kept;
        n_count      = r_count;
        n_px         = r_px;
        n_py         = r_py;
        n_out_valid  = r_out_valid & ~w_out_acc;
        n_out_x      = r_out_x;
        n_out_y      = r_out_y;
        n_out_kept   = r_out_kept;
        n_out_done   = r_out_done;
        n_out_count  = r_out_count;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_beam_angle = w_angle;
                    // scan end: next sample reloads the start angle, count restarts
                    n_first      = i_pt.scan_end;
                    n_kept_total = i_pt.scan_end ? '0 : w_count;
                    n_last       = i_pt.scan_end;
                    n_kept       = w_kept;
                    n_count      = w_count;
                    n_px         = '0;
                    n_py         = '0;
                    n_state      = w_kept ? S_CONV : S_EMIT;
                end
            end
            S_CONV: begin
                if (w_rsp.done) begin
                    n_px    = w_rsp.x;
                    n_py    = w_rsp.y;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // hand over once the output register is free or being drained
                if (!r_out_valid || o_pt.ready) begin
                    n_out_valid = 1'b1;
                    n_out_x     = r_px;
                    n_out_y     = r_py;
                    n_out_kept  = r_kept;
                    n_out_done  = r_last;
                    n_out_count = r_count;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_gate_lo     <= '0;
            r_gate_hi     <= '1;
            r_angle_start <= '0;
            r_angle_step  <= '0;
            r_beam_angle  <= '0;
            r_first       <= 1'b1;
            r_kept_total  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_gate_lo     <= n_gate_lo;
            r_gate_hi     <= n_gate_hi;
            r_angle_start <= n_angle_start;
            r_angle_step  <= n_angle_step;
            r_beam_angle  <= n_beam_angle;
            r_first       <= n_first;
            r_kept_total  <= n_kept_total;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last      <= n_last;
        r_kept      <= n_kept;
        r_count     <= n_count;
        r_px        <= n_px;
        r_py        <= n_py;
        r_out_x     <= n_out_x;
        r_out_y     <= n_out_y;
        r_out_kept  <= n_out_kept;
        r_out_done  <= n_out_done;
        r_out_count <= n_out_count;
    end

    assign o_pt.valid      = r_out_valid;
    assign o_pt.x_mm       = r_out_x;
    assign o_pt.y_mm       = r_out_y;
    assign o_pt.point_kept = r_out_kept;
    assign o_pt.scan_done  = r_out_done;
    assign o_pt.kept_count = r_out_count;

endmodule

`default_nettype wire

// ===== hw/rtl/lpc_cordic.sv =====
`default_nettype none

module lpc_cordic (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire lpc_pkg::t_cordic_req i_req,
    output lpc_pkg::t_cordic_rsp o_rsp
);
    import lpc_pkg::*;

    // round to nearest unit, undo the half turn, clamp
    function automatic logic signed [XY_W-1:0] finish(input logic signed [ACC_W-1:0] v,
                                                      input logic neg);
        logic [ACC_W:0]               s;
        logic signed [ACC_W-16:0]     q;
        logic signed [ACC_W-15:0]     n;
        logic signed [ACC_W-15:0]     lim;
        logic signed [XY_W-1:0]       res;
        s   = {v[ACC_W-1], v} + (ACC_W+1)'(32768);
        q   = $signed(s[ACC_W:16]);
        n   = neg ? -{q[ACC_W-16], q} : {q[ACC_W-16], q};
        lim = (ACC_W-14)'(XY_LIMIT);
        if (n > lim) begin
            res = XY_W'(lim);
        end else if (n < -lim) begin
            res = XY_W'(-lim);
        end else begin
            res = XY_W'(n);
        end
        return res;
    endfunction

    t_cordic_state r_state, n_state;

    logic [RANGE_W-1:0]       r_range, n_range;
    logic                     r_flip, n_flip;
    logic signed [Z_W-1:0]    r_z, n_z;
    logic signed [ACC_W-1:0]  r_x, n_x;
    logic signed [ACC_W-1:0]  r_y, n_y;
    logic [STEP_W-1:0]        r_step, n_step;
    logic signed [XY_W-1:0]   r_rx, n_rx;
    logic signed [XY_W-1:0]   r_ry, n_ry;
    logic                     r_done, n_done;

    logic [ANGLE_W-1:0]       w_rel;
    logic                     w_flip;
    logic [ANGLE_W-1:0]       w_zang;
    logic [47:0]              w_prod;
    logic signed [ACC_W-1:0]  w_dx;
    logic signed [ACC_W-1:0]  w_dy;
    logic signed [Z_W-1:0]    w_at;

    // angles in the left half plane are turned by half a turn
    assign w_rel  = i_req.angle - ANGLE_W'(16'h4000);
    assign w_flip = ~w_rel[ANGLE_W-1];
    assign w_zang = i_req.angle + (w_flip ? ANGLE_W'(16'h8000) : '0);

    assign w_prod = 48'(r_range) * 48'(GAIN_Q32);

    assign w_dx = r_y >>> r_step;
    assign w_dy = r_x >>> r_step;
    assign w_at = $signed(Z_W'(atan_turn32(5'(r_step))));

    always_comb begin
        n_state = r_state;
        n_range = r_range;
        n_flip  = r_flip;
        n_z     = r_z;
        n_x     = r_x;
        n_y     = r_y;
        n_step  = r_step;
        n_rx    = r_rx;
        n_ry    = r_ry;
        n_done  = 1'b0;
        case (r_state)
            C_IDLE: begin
                if (i_req.start) begin
                    n_range = i_req.range;
                    n_flip  = w_flip;
                    n_z     = Z_W'($signed({w_zang, 16'h0000}));
                    n_state = C_MUL;
                end
            end
            C_MUL: begin
                // gain compensation folded into the start vector
                n_x     = $signed(ACC_W'(w_prod[47:16]));
                n_y     = '0;
                n_step  = '0;
                n_state = C_ROT;
            end
            C_ROT: begin
                if (!r_z[Z_W-1]) begin
                    n_x = r_x - w_dx;
                    n_y = r_y + w_dy;
                    n_z = r_z - w_at;
                end else begin
                    n_x = r_x + w_dx;
                    n_y = r_y - w_dy;
                    n_z = r_z + w_at;
                end
                if (r_step == STEP_W'(CORDIC_STEPS - 1)) begin
                    n_state = C_RND;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            C_RND: begin
                n_rx    = finish(r_x, r_flip);
                n_ry    = finish(r_y, r_flip);
                n_done  = 1'b1;
                n_state = C_IDLE;
            end
            default: begin
                n_state = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_range <= n_range;
        r_flip  <= n_flip;
        r_z     <= n_z;
        r_x     <= n_x;
        r_y     <= n_y;
        r_step  <= n_step;
        r_rx    <= n_rx;
        r_ry    <= n_ry;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.x    = r_rx;
    assign o_rsp.y    = r_ry;

endmodule

`default_nettype wire

// ===== hw/rtl/lpc_checker.sv =====
`default_nettype none

`include "lidar_polar_to_cartesian_macros.svh"

module lpc_checker (
    input wire                                 i_clk,
    input wire                                 i_rst_n,
    input wire                                 i_in_valid,
    input wire                                 i_in_ready,
    input wire                                 i_out_valid,
    input wire                                 i_out_kept,
    input wire signed [lpc_pkg::XY_W-1:0]      i_out_x,
    input wire signed [lpc_pkg::XY_W-1:0]      i_out_y
);
    import lpc_pkg::*;

    // a dropped sample shows the origin
    `LPC_ASSERT(a_drop_zero, (i_out_valid && !i_out_kept) |-> (i_out_x == '0 && i_out_y == '0), "dropped item with nonzero point")

    // clamp keeps the most negative code out of x
    `LPC_ASSERT(a_x_clamped, (i_out_valid && i_out_x[XY_W-1]) |-> (i_out_x[XY_W-2:0] != '0), "x outside clamp range")

    // one item at a time
    `LPC_ASSERT_NEXT(a_busy_after_accept, i_in_valid && i_in_ready, !i_in_ready, "item accepted while previous still busy")

    // a result never appears in the cycle right after acceptance
    `LPC_ASSERT_NEXT(a_no_early_result, i_in_valid && i_in_ready, !$rose(i_out_valid), "result raised too early")

endmodule

bind lidar_polar_to_cartesian lpc_checker u_lpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pt.valid),
    .i_in_ready  (i_pt.ready),
    .i_out_valid (o_pt.valid),
    .i_out_kept  (o_pt.point_kept),
    .i_out_x     (o_pt.x_mm),
    .i_out_y     (o_pt.y_mm)
);

`default_nettype wire
